@@ src/lfmc_pkg.sv @@
// Shared types and codes of the launcher feed mode controller.
// No dependencies; the register bank, mode logic and top level refer to it by scoped names.
`default_nettype none

package lfmc_pkg;

    // Width of every configuration register and of the write data port.
    localparam int CFG_W = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEFT_WHEEL_TARGET  = 3'd0,
        CFG_RIGHT_WHEEL_TARGET = 3'd1,
        CFG_WHEEL_TOLERANCE    = 3'd2,
        CFG_STALL_SPEED        = 3'd3,
        CFG_JAM_TICKS          = 3'd4,
        CFG_REVERSE_TICKS      = 3'd5,
        CFG_WHEEL_MIN_SPEED    = 3'd6,
        CFG_LOST_TICKS         = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        SW_OTHER  = 2'd0,
        SW_UP     = 2'd1,
        SW_DOWN   = 2'd2,
        SW_MIDDLE = 2'd3
    } t_switch;

    typedef enum logic [1:0] {
        WHEEL_OFF    = 2'd0,
        WHEEL_SPINUP = 2'd1,
        WHEEL_READY  = 2'd2
    } t_wheel_state;

    typedef enum logic [1:0] {
        FEED_STOP    = 2'd0,
        FEED_BURST   = 2'd1,
        FEED_REVERSE = 2'd2
    } t_feed_mode;

    // Targets are two's complement, the rest unsigned.
    typedef struct packed {
        logic [CFG_W-1:0] left_wheel_target;
        logic [CFG_W-1:0] right_wheel_target;
        logic [CFG_W-1:0] wheel_tolerance;
        logic [CFG_W-1:0] stall_speed;
        logic [CFG_W-1:0] jam_ticks;
        logic [CFG_W-1:0] reverse_ticks;
        logic [CFG_W-1:0] wheel_min_speed;
        logic [CFG_W-1:0] lost_ticks;
    } t_cfg;

    localparam logic [CFG_W-1:0] JAM_TICKS_RESET = 16'd1;

endpackage

`default_nettype wire

@@ src/lfmc_tick_if.sv @@
// Request channel of the launcher feed mode controller: one control tick.
// Stand-alone interface; speed width set by its parameter.
`default_nettype none

interface lfmc_tick_if #(
    parameter int SPEED_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    switch_position;
    logic                          remote_offline;
    logic                          fire_request;
    logic signed [SPEED_WIDTH-1:0] left_wheel_speed;
    logic signed [SPEED_WIDTH-1:0] right_wheel_speed;
    logic signed [SPEED_WIDTH-1:0] feeder_speed;

    modport source (
        output valid, switch_position, remote_offline, fire_request,
               left_wheel_speed, right_wheel_speed, feeder_speed,
        input  ready
    );

    modport sink (
        input  valid, switch_position, remote_offline, fire_request,
               left_wheel_speed, right_wheel_speed, feeder_speed,
        output ready
    );
endinterface

`default_nettype wire

@@ src/lfmc_result_if.sv @@
// Result channel of the launcher feed mode controller: one result per tick.
// Stand-alone interface.
`default_nettype none

interface lfmc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] wheel_state;
    logic [1:0] feed_mode;
    logic       wheel_running;
    logic       auto_wheel_on;

    modport source (
        output valid, wheel_state, feed_mode, wheel_running, auto_wheel_on,
        input  ready
    );

    modport sink (
        input  valid, wheel_state, feed_mode, wheel_running, auto_wheel_on,
        output ready
    );
endinterface

`default_nettype wire

@@ src/lfmc_cfg_regs.sv @@
// Configuration register bank of the launcher feed mode controller.
// Depends on lfmc_pkg.
`default_nettype none

module lfmc_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lfmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [lfmc_pkg::CFG_W-1:0]     i_cfg_wdata,
    output lfmc_pkg::t_cfg                      o_cfg
);

    lfmc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{jam_ticks: lfmc_pkg::JAM_TICKS_RESET, default: '0};
        end else if (i_cfg_we) begin
            case (lfmc_pkg::t_cfg_index'(i_cfg_index))
                lfmc_pkg::CFG_LEFT_WHEEL_TARGET:  r_cfg.left_wheel_target  <= i_cfg_wdata;
                lfmc_pkg::CFG_RIGHT_WHEEL_TARGET: r_cfg.right_wheel_target <= i_cfg_wdata;
                lfmc_pkg::CFG_WHEEL_TOLERANCE:    r_cfg.wheel_tolerance    <= i_cfg_wdata;
                lfmc_pkg::CFG_STALL_SPEED:        r_cfg.stall_speed        <= i_cfg_wdata;
                lfmc_pkg::CFG_JAM_TICKS:          r_cfg.jam_ticks          <= i_cfg_wdata;
                lfmc_pkg::CFG_REVERSE_TICKS:      r_cfg.reverse_ticks      <= i_cfg_wdata;
                lfmc_pkg::CFG_WHEEL_MIN_SPEED:    r_cfg.wheel_min_speed    <= i_cfg_wdata;
                lfmc_pkg::CFG_LOST_TICKS:         r_cfg.lost_ticks         <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ src/lfmc_mode_logic.sv @@
// Next-state logic of one control tick: target-lost observer, then mode step.
// Purely combinational; depends on lfmc_pkg.
`default_nettype none

module lfmc_mode_logic #(
    parameter int SPEED_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire lfmc_pkg::t_cfg           i_cfg,
    input  wire lfmc_pkg::t_switch        i_switch,
    input  wire logic                     i_offline,
    input  wire logic                     i_fire,
    input  wire logic signed [SPEED_WIDTH-1:0] i_left,
    input  wire logic signed [SPEED_WIDTH-1:0] i_right,
    input  wire logic signed [SPEED_WIDTH-1:0] i_feeder,
    input  wire lfmc_pkg::t_wheel_state   i_wheel_state,
    input  wire lfmc_pkg::t_feed_mode     i_feed_mode,
    input  wire logic [COUNT_WIDTH-1:0]   i_jam_count,
    input  wire logic [COUNT_WIDTH-1:0]   i_reverse_count,
    input  wire logic [COUNT_WIDTH-1:0]   i_lost_count,
    output lfmc_pkg::t_wheel_state        o_wheel_state,
    output lfmc_pkg::t_feed_mode          o_feed_mode,
    output logic [COUNT_WIDTH-1:0]        o_jam_count,
    output logic [COUNT_WIDTH-1:0]        o_reverse_count,
    output logic [COUNT_WIDTH-1:0]        o_lost_count,
    output logic                          o_wheel_running,
    output logic                          o_auto_wheel_on
);

    // Compare counters and thresholds at the wider of the two widths.
    localparam int CMP_W = (COUNT_WIDTH > lfmc_pkg::CFG_W) ? COUNT_WIDTH : lfmc_pkg::CFG_W;
    // Speed differences need one bit beyond the wider operand.
    localparam int DIF_W =
        ((SPEED_WIDTH > lfmc_pkg::CFG_W) ? SPEED_WIDTH : lfmc_pkg::CFG_W) + 1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        sat_inc = (&c) ? c : c + 1'b1;
    endfunction

    logic signed [DIF_W-1:0] left_x, right_x, feeder_x, tgt_l_x, tgt_r_x, err_l, err_r;
    logic [DIF_W-1:0]        mag_err_l, mag_err_r, mag_left, mag_feeder;
    logic [DIF_W-1:0]        tol_x, stall_x, min_x;
    logic [CMP_W-1:0]        lost_ticks_x, jam_x, jam_ticks_x, rev_x, rev_ticks_x;
    logic [COUNT_WIDTH-1:0]  lost_inc, lost_next;
    logic                    cmd, ready, running, stalled;
    lfmc_pkg::t_wheel_state  host_ws;
    lfmc_pkg::t_feed_mode    host_fm;

    // Wheel speed checks.
    assign left_x    = DIF_W'(i_left);
    assign right_x   = DIF_W'(i_right);
    assign feeder_x  = DIF_W'(i_feeder);
    assign tgt_l_x   = DIF_W'($signed(i_cfg.left_wheel_target));
    assign tgt_r_x   = DIF_W'($signed(i_cfg.right_wheel_target));
    assign err_l     = left_x - tgt_l_x;
    assign err_r     = right_x - tgt_r_x;
    assign mag_err_l = err_l[DIF_W-1] ? $unsigned(-err_l) : $unsigned(err_l);
    assign mag_err_r = err_r[DIF_W-1] ? $unsigned(-err_r) : $unsigned(err_r);
    assign mag_left  = left_x[DIF_W-1] ? $unsigned(-left_x) : $unsigned(left_x);
    assign mag_feeder = feeder_x[DIF_W-1] ? $unsigned(-feeder_x) : $unsigned(feeder_x);
    assign tol_x     = DIF_W'(i_cfg.wheel_tolerance);
    assign stall_x   = DIF_W'(i_cfg.stall_speed);
    assign min_x     = DIF_W'(i_cfg.wheel_min_speed);

    assign ready   = (mag_err_l <= tol_x) && (mag_err_r <= tol_x);
    assign running = mag_left >= min_x;
    assign stalled = mag_feeder < stall_x;

    // Observer: count target-lost ticks, clamp at the threshold.
    assign lost_ticks_x = CMP_W'(i_cfg.lost_ticks);
    assign lost_inc     = sat_inc(i_lost_count);

    always_comb begin
        if ((i_switch == lfmc_pkg::SW_MIDDLE || i_offline) && !i_fire) begin
            lost_next = (CMP_W'(lost_inc) > lost_ticks_x) ?
                        COUNT_WIDTH'(i_cfg.lost_ticks) : lost_inc;
        end else begin
            lost_next = '0;
        end
    end

    assign cmd = CMP_W'(lost_next) < lost_ticks_x;

    // Host decision, shared by the middle switch and the offline override.
    assign host_ws = cmd ? (ready ? lfmc_pkg::WHEEL_READY : lfmc_pkg::WHEEL_SPINUP)
                         : lfmc_pkg::WHEEL_OFF;
    assign host_fm = (i_fire && host_ws == lfmc_pkg::WHEEL_READY) ?
                     lfmc_pkg::FEED_BURST : lfmc_pkg::FEED_STOP;

    assign jam_x       = CMP_W'(i_jam_count);
    assign jam_ticks_x = CMP_W'(i_cfg.jam_ticks);
    assign rev_x       = CMP_W'(i_reverse_count);
    assign rev_ticks_x = CMP_W'(i_cfg.reverse_ticks);

    always_comb begin
        lfmc_pkg::t_wheel_state ws;
        lfmc_pkg::t_feed_mode   fm;
        logic [COUNT_WIDTH-1:0] jam;
        logic [COUNT_WIDTH-1:0] rev;

        ws  = i_wheel_state;
        fm  = i_feed_mode;
        jam = i_jam_count;
        rev = i_reverse_count;

        case (i_switch)
            lfmc_pkg::SW_DOWN: begin
                ws = lfmc_pkg::WHEEL_OFF;
                fm = lfmc_pkg::FEED_STOP;
            end
            lfmc_pkg::SW_MIDDLE: begin
                ws = host_ws;
                fm = host_fm;
            end
            lfmc_pkg::SW_UP: begin
                ws = lfmc_pkg::WHEEL_READY;
                fm = lfmc_pkg::FEED_BURST;
            end
            default: begin
                // other position: hold state and mode
            end
        endcase

        // Jam handling runs only in burst feed.
        if (fm == lfmc_pkg::FEED_BURST) begin
            if (jam_x >= jam_ticks_x) begin
                fm = lfmc_pkg::FEED_REVERSE;
            end
            if (stalled && jam_x < jam_ticks_x) begin
                jam = sat_inc(i_jam_count);
                rev = '0;
            end else if (jam_x == jam_ticks_x && rev_x < rev_ticks_x) begin
                rev = sat_inc(i_reverse_count);
            end else begin
                jam = '0;
            end
        end

        if (!running) begin
            fm = lfmc_pkg::FEED_STOP;
        end

        // Offline remote overrides the switch.
        if (i_offline) begin
            ws = host_ws;
            fm = host_fm;
        end

        o_wheel_state   = ws;
        o_feed_mode     = fm;
        o_jam_count     = jam;
        o_reverse_count = rev;
    end

    assign o_lost_count    = lost_next;
    assign o_wheel_running = running;
    assign o_auto_wheel_on = cmd;

endmodule

`default_nettype wire

@@ src/launcher_feed_mode_controller.sv @@
// Top level of the launcher feed mode controller: tick register, state, result register.
// Depends on lfmc_pkg, lfmc_tick_if, lfmc_result_if, lfmc_cfg_regs, lfmc_mode_logic.
`default_nettype none

// Channel     Dir  Handshake     Payload
// i_tick      in   valid/ready   switch_position, remote_offline, fire_request,
//                                left/right_wheel_speed, feeder_speed
// o_result    out  valid/ready   wheel_state, feed_mode, wheel_running, auto_wheel_on
// i_cfg_*     in   write enable  index (3 bits), data (16 bits), no read-back
//
// One request per cycle sustained while results are taken; each tick goes from acceptance
// to its result through the tick register, then the result register.
// The controller state (wheel state, feed mode, jam, reverse and lost counters)
// updates in the same cycle the tick moves into the result register, so the next
// tick always sees it. Reset clears state and valids and loads configuration defaults.
// A stalled result holds; one more tick is taken into the tick register meanwhile.

module launcher_feed_mode_controller #(
    parameter int SPEED_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    lfmc_tick_if.sink                             i_tick,
    lfmc_result_if.source                         o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [lfmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [lfmc_pkg::CFG_W-1:0]       i_cfg_wdata
);

    lfmc_pkg::t_cfg cfg;

    // Tick register.
    logic                          r_in_valid;
    logic [1:0]                    r_switch;
    logic                          r_offline;
    logic                          r_fire;
    logic signed [SPEED_WIDTH-1:0] r_left;
    logic signed [SPEED_WIDTH-1:0] r_right;
    logic signed [SPEED_WIDTH-1:0] r_feeder;

    // Controller state.
    lfmc_pkg::t_wheel_state r_wheel_state, n_wheel_state;
    lfmc_pkg::t_feed_mode   r_feed_mode, n_feed_mode;
    logic [COUNT_WIDTH-1:0] r_jam_count, n_jam_count;
    logic [COUNT_WIDTH-1:0] r_reverse_count, n_reverse_count;
    logic [COUNT_WIDTH-1:0] r_lost_count, n_lost_count;
    logic                   n_wheel_running, n_auto_wheel_on;

    // Result register.
    logic       r_out_valid;
    logic [1:0] r_out_wheel_state;
    logic [1:0] r_out_feed_mode;
    logic       r_out_wheel_running;
    logic       r_out_auto_wheel_on;

    logic advance;
    logic accept;

    lfmc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lfmc_mode_logic #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mode_logic (
        .i_cfg           (cfg),
        .i_switch        (lfmc_pkg::t_switch'(r_switch)),
        .i_offline       (r_offline),
        .i_fire          (r_fire),
        .i_left          (r_left),
        .i_right         (r_right),
        .i_feeder        (r_feeder),
        .i_wheel_state   (r_wheel_state),
        .i_feed_mode     (r_feed_mode),
        .i_jam_count     (r_jam_count),
        .i_reverse_count (r_reverse_count),
        .i_lost_count    (r_lost_count),
        .o_wheel_state   (n_wheel_state),
        .o_feed_mode     (n_feed_mode),
        .o_jam_count     (n_jam_count),
        .o_reverse_count (n_reverse_count),
        .o_lost_count    (n_lost_count),
        .o_wheel_running (n_wheel_running),
        .o_auto_wheel_on (n_auto_wheel_on)
    );

    // Advance the held tick when the result register is free or being emptied.
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || advance;
    assign accept       = i_tick.valid && i_tick.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the request payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_switch  <= i_tick.switch_position;
            r_offline <= i_tick.remote_offline;
            r_fire    <= i_tick.fire_request;
            r_left    <= i_tick.left_wheel_speed;
            r_right   <= i_tick.right_wheel_speed;
            r_feeder  <= i_tick.feeder_speed;
        end
    end

    // Commit controller state once per advanced tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_state   <= lfmc_pkg::WHEEL_OFF;
            r_feed_mode     <= lfmc_pkg::FEED_STOP;
            r_jam_count     <= '0;
            r_reverse_count <= '0;
            r_lost_count    <= '0;
        end else if (advance) begin
            r_wheel_state   <= n_wheel_state;
            r_feed_mode     <= n_feed_mode;
            r_jam_count     <= n_jam_count;
            r_reverse_count <= n_reverse_count;
            r_lost_count    <= n_lost_count;
        end
    end

    // Result register: load on advance, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_wheel_state   <= n_wheel_state;
            r_out_feed_mode     <= n_feed_mode;
            r_out_wheel_running <= n_wheel_running;
            r_out_auto_wheel_on <= n_auto_wheel_on;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.wheel_state   = r_out_wheel_state;
    assign o_result.feed_mode     = r_out_feed_mode;
    assign o_result.wheel_running = r_out_wheel_running;
    assign o_result.auto_wheel_on = r_out_auto_wheel_on;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for the launcher feed mode controller: control ticks in, status results out.
// Each result is checked against a model of the observer and mode step kept in this file.
// Depends on lfmc_pkg, lfmc_tick_if, lfmc_result_if and launcher_feed_mode_controller.

module tb;
    import lfmc_pkg::*;

    localparam int SPEED_W     = 16;
    localparam int COUNT_MAX   = 65535;
    localparam int CYCLE_LIMIT = 800000;
    localparam int LONG_HOLD   = 200;
    localparam int SOAK_TICKS  = 300;
    localparam int SOAK_LOST   = 250;
    localparam int TAIL_CYCLES = 8;

    // Kinds of register setting for one phase.
    localparam int SET_RANDOM = 0;
    localparam int SET_LOW    = 1;
    localparam int SET_HIGH   = 2;

    typedef struct {
        t_switch                    sw;
        logic                       offline;
        logic                       fire;
        logic signed [SPEED_W-1:0]  left;
        logic signed [SPEED_W-1:0]  right;
        logic signed [SPEED_W-1:0]  feeder;
    } t_tick;

    typedef struct {
        t_wheel_state ws;
        t_feed_mode   fm;
        logic         running;
        logic         auto_on;
    } t_status;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_wdata;

    lfmc_tick_if #(.SPEED_WIDTH(SPEED_W)) tick_ch ();
    lfmc_result_if                        result_ch ();

    launcher_feed_mode_controller #(
        .SPEED_WIDTH (SPEED_W),
        .COUNT_WIDTH (16)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests waiting to be offered, and the status each accepted request must produce.
    t_tick   pending_ticks[$];
    t_status status_due[$];
    t_tick   cur_tick;
    bit      tick_taken;

    // Shadow of the register file and of the controller state.
    logic [CFG_W-1:0] cfg_shadow [8];
    t_wheel_state     m_wheel = WHEEL_OFF;
    t_feed_mode       m_feed  = FEED_STOP;
    int               m_jam   = 0;
    int               m_rev   = 0;
    int               m_lost  = 0;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_asked = 0;
    int stall_done  = 0;
    int stall_left  = 0;

    int cycle_count  = 0;
    int error_count  = 0;
    int ticks_taken  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;

    // ------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------
    function automatic int magnitude(int x);
        return (x < 0) ? -x : x;
    endfunction

    // Counters stop at their largest value instead of wrapping.
    function automatic int count_up(int c);
        return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
    endfunction

    // Host control: wheel follows the auto command, feed only on a ready wheel and fire.
    task automatic host_decide(bit cmd, bit wheels_ok, bit fire);
        if (cmd)
            m_wheel = wheels_ok ? WHEEL_READY : WHEEL_SPINUP;
        else
            m_wheel = WHEEL_OFF;
        m_feed = (fire && m_wheel == WHEEL_READY) ? FEED_BURST : FEED_STOP;
    endtask

    task automatic step_controller(input t_tick t, output t_status s);
        int  left, right, feeder, tgt_l, tgt_r, tol, lost_lim, jam_lim;
        int  stall_lim, rev_lim, min_lim;
        bit  cmd, wheels_ok, running;
        left      = int'(t.left);
        right     = int'(t.right);
        feeder    = int'(t.feeder);
        tgt_l     = int'($signed(cfg_shadow[CFG_LEFT_WHEEL_TARGET]));
        tgt_r     = int'($signed(cfg_shadow[CFG_RIGHT_WHEEL_TARGET]));
        tol       = int'(cfg_shadow[CFG_WHEEL_TOLERANCE]);
        lost_lim  = int'(cfg_shadow[CFG_LOST_TICKS]);
        jam_lim   = int'(cfg_shadow[CFG_JAM_TICKS]);
        stall_lim = int'(cfg_shadow[CFG_STALL_SPEED]);
        rev_lim   = int'(cfg_shadow[CFG_REVERSE_TICKS]);
        min_lim   = int'(cfg_shadow[CFG_WHEEL_MIN_SPEED]);

        // Observer first: count target-lost ticks, clamp at the threshold.
        if ((t.sw == SW_MIDDLE || t.offline) && !t.fire) begin
            m_lost = count_up(m_lost);
            if (m_lost > lost_lim)
                m_lost = lost_lim;
        end else begin
            m_lost = 0;
        end
        cmd       = m_lost < lost_lim;
        wheels_ok = magnitude(left - tgt_l) <= tol && magnitude(right - tgt_r) <= tol;

        // Mode step; the other switch position keeps state and mode.
        case (t.sw)
            SW_DOWN: begin
                m_wheel = WHEEL_OFF;
                m_feed  = FEED_STOP;
            end
            SW_MIDDLE: host_decide(cmd, wheels_ok, t.fire);
            SW_UP: begin
                m_wheel = WHEEL_READY;
                m_feed  = FEED_BURST;
            end
            default: ;
        endcase

        // Jam handling only while feeding.
        if (m_feed == FEED_BURST) begin
            if (m_jam >= jam_lim)
                m_feed = FEED_REVERSE;
            if (magnitude(feeder) < stall_lim && m_jam < jam_lim) begin
                m_jam = count_up(m_jam);
                m_rev = 0;
            end else if (m_jam == jam_lim && m_rev < rev_lim) begin
                m_rev = count_up(m_rev);
            end else begin
                m_jam = 0;
            end
        end

        running = magnitude(left) >= min_lim;
        if (!running)
            m_feed = FEED_STOP;

        // An offline remote overrides whatever the switch decided.
        if (t.offline)
            host_decide(cmd, wheels_ok, t.fire);

        s.ws      = m_wheel;
        s.fm      = m_feed;
        s.running = running;
        s.auto_on = cmd;
    endtask

    // ------------------------------------------------------------------
    // Driver: change request signals on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
        end else if (!tick_ch.valid || tick_taken) begin
            // Previous request gone (or none): offer the next one, or idle.
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_tick = pending_ticks.pop_front();
                tick_ch.switch_position   <= cur_tick.sw;
                tick_ch.remote_offline    <= cur_tick.offline;
                tick_ch.fire_request      <= cur_tick.fire;
                tick_ch.left_wheel_speed  <= cur_tick.left;
                tick_ch.right_wheel_speed <= cur_tick.right;
                tick_ch.feeder_speed      <= cur_tick.feeder;
                tick_ch.valid             <= 1'b1;
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure, plus a long hold whenever one is asked for.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else if (stall_done != stall_asked) begin
            stall_done++;
            stall_left = LONG_HOLD;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge
    // ------------------------------------------------------------------
    task automatic report_field(string name, logic [1:0] want_v, logic [1:0] got_v);
        error_count++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : monitor
        t_status want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d results still outstanding", $time, status_due.size());
            $display("[launcher_feed_mode_controller] ERROR");
            $finish;
        end else if (!i_rst_n) begin
            tick_taken = 1'b0;
        end else begin
            // Check the result before adding this cycle's expectation.
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (status_due.size() == 0) begin
                    error_count++;
                    $display("%0t ns: result with nothing outstanding, expected none,%s",
                             $time, " got");
                    $display("    wheel_state %0d, feed_mode %0d",
                             result_ch.wheel_state, result_ch.feed_mode);
                end else begin
                    want = status_due.pop_front();
                    if (result_ch.wheel_state !== want.ws)
                        report_field("wheel_state", want.ws, result_ch.wheel_state);
                    if (result_ch.feed_mode !== want.fm)
                        report_field("feed_mode", want.fm, result_ch.feed_mode);
                    if (result_ch.wheel_running !== want.running)
                        report_field("wheel_running", 2'(want.running),
                                     2'(result_ch.wheel_running));
                    if (result_ch.auto_wheel_on !== want.auto_on)
                        report_field("auto_wheel_on", 2'(want.auto_on),
                                     2'(result_ch.auto_wheel_on));
                end
            end
            tick_taken = tick_ch.valid && tick_ch.ready;
            if (tick_taken) begin
                step_controller(cur_tick, want);
                status_due.push_back(want);
                ticks_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Hold until every request is out and every result is back, then let the pipe settle.
    task automatic drain_all();
        while (pending_ticks.size() != 0 || tick_ch.valid === 1'b1 || status_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_index idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        cfg_shadow[idx] = val;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_tick(t_switch sw, bit off, bit fire, int l, int r, int f);
        t_tick t;
        t.sw      = sw;
        t.offline = off;
        t.fire    = fire;
        t.left    = SPEED_W'(l);
        t.right   = SPEED_W'(r);
        t.feeder  = SPEED_W'(f);
        pending_ticks.push_back(t);
    endtask

    function automatic logic [CFG_W-1:0] choose_setting(int kind, t_cfg_index idx);
        logic [CFG_W-1:0] lo, hi, usual;
        int v;
        int roll;
        roll = $urandom_range(9);
        case (idx)
            CFG_LEFT_WHEEL_TARGET, CFG_RIGHT_WHEEL_TARGET: begin
                lo    = 16'h8000;
                hi    = 16'h7FFF;
                v     = int'($urandom_range(16000)) - 8000;
                usual = v[CFG_W-1:0];
            end
            CFG_WHEEL_TOLERANCE: begin
                lo    = '0;
                hi    = 16'hFFFF;
                usual = CFG_W'($urandom_range(400));
            end
            CFG_STALL_SPEED, CFG_WHEEL_MIN_SPEED: begin
                lo    = '0;
                hi    = 16'h8000;
                usual = CFG_W'($urandom_range(3000));
            end
            CFG_JAM_TICKS, CFG_LOST_TICKS: begin
                lo    = '0;
                hi    = 16'hFFFF;
                usual = CFG_W'($urandom_range(8, 1));
            end
            default: begin
                lo    = '0;
                hi    = 16'hFFFF;
                usual = CFG_W'($urandom_range(6));
            end
        endcase
        if (kind == SET_LOW || (kind == SET_RANDOM && roll == 0))
            return lo;
        if (kind == SET_HIGH || (kind == SET_RANDOM && roll == 1))
            return hi;
        return usual;
    endfunction

    function automatic logic signed [SPEED_W-1:0] near_speed(int center, int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[SPEED_W-1:0];
    endfunction

    // Mostly runs of one switch position with speeds around the targets, so the jam,
    // reverse and target-lost counters get to climb; some requests are plain noise.
    task automatic queue_random(int count);
        t_tick   t;
        t_switch run_sw;
        bit      run_off, run_fire;
        int      run_len, roll, spread, stall, min_spd, mag_v, tgt_l, tgt_r, queued, tol;
        tgt_l   = int'($signed(cfg_shadow[CFG_LEFT_WHEEL_TARGET]));
        tgt_r   = int'($signed(cfg_shadow[CFG_RIGHT_WHEEL_TARGET]));
        stall   = int'(cfg_shadow[CFG_STALL_SPEED]);
        min_spd = int'(cfg_shadow[CFG_WHEEL_MIN_SPEED]);
        tol     = int'(cfg_shadow[CFG_WHEEL_TOLERANCE]);
        queued  = 0;
        while (queued < count) begin
            run_len = $urandom_range(12, 1);
            roll    = $urandom_range(19);
            run_sw  = (roll < 7) ? SW_UP : (roll < 14) ? SW_MIDDLE : (roll < 17) ? SW_DOWN
                    : SW_OTHER;
            run_off  = ($urandom_range(7) == 0);
            run_fire = ($urandom_range(3) != 0);
            // Tight spread sits on the tolerance edge, wide spread crosses it often.
            spread = $urandom_range(1) ? tol + 1 : 2 * tol + 16;
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(99) < 12) begin
                    t.sw      = t_switch'($urandom_range(3));
                    t.offline = 1'($urandom_range(1));
                    t.fire    = 1'($urandom_range(1));
                    t.left    = SPEED_W'($urandom);
                    t.right   = SPEED_W'($urandom);
                    t.feeder  = SPEED_W'($urandom);
                end else begin
                    t.sw      = run_sw;
                    t.offline = run_off;
                    t.fire    = ($urandom_range(9) == 0) ? !run_fire : run_fire;
                    if ($urandom_range(9) == 0)
                        t.left = near_speed(($urandom_range(1) ? 1 : -1) * min_spd, 1);
                    else
                        t.left = near_speed(tgt_l, spread);
                    t.right = near_speed(tgt_r, spread);
                    if (stall > 0 && $urandom_range(99) < 40) begin
                        mag_v    = $urandom_range(stall - 1);
                        t.feeder = SPEED_W'($urandom_range(1) ? -mag_v : mag_v);
                    end else begin
                        t.feeder = SPEED_W'($urandom);
                    end
                end
                pending_ticks.push_back(t);
                queued++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_tick t;
        int    kind;
        // Drive every input to a known value before the first edge.
        i_rst_n                   = 1'b0;
        i_cfg_we                  = 1'b0;
        i_cfg_index               = CFG_LEFT_WHEEL_TARGET;
        i_cfg_wdata               = '0;
        tick_ch.valid             = 1'b0;
        tick_ch.switch_position   = SW_OTHER;
        tick_ch.remote_offline    = 1'b0;
        tick_ch.fire_request      = 1'b0;
        tick_ch.left_wheel_speed  = '0;
        tick_ch.right_wheel_speed = '0;
        tick_ch.feeder_speed      = '0;
        result_ch.ready           = 1'b0;
        for (int i = 0; i < 8; i++)
            cfg_shadow[i] = '0;
        cfg_shadow[CFG_JAM_TICKS] = JAM_TICKS_RESET;
        send_idle_pct = 34;
        recv_idle_pct = 87;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: the other, up and down switch positions and the speed extremes.
        add_tick(SW_OTHER, 0, 0, 0, 0, 0);
        add_tick(SW_UP,    0, 1, 32767, -32768, 32767);
        add_tick(SW_DOWN,  1, 1, -32768, 32767, -32768);
        drain_all();

        write_cfg(CFG_LEFT_WHEEL_TARGET,  16'd1000);
        write_cfg(CFG_RIGHT_WHEEL_TARGET, -16'sd1000);
        write_cfg(CFG_WHEEL_TOLERANCE,    16'd50);
        write_cfg(CFG_STALL_SPEED,        16'd100);
        write_cfg(CFG_JAM_TICKS,          16'd3);
        write_cfg(CFG_REVERSE_TICKS,      16'd2);
        write_cfg(CFG_WHEEL_MIN_SPEED,    16'd500);
        write_cfg(CFG_LOST_TICKS,         16'd4);
        // Host spins up and feeds, then the feeder stalls into a jam and reverses out.
        add_tick(SW_MIDDLE, 0, 1, 1000, -1000, 500);
        add_tick(SW_MIDDLE, 0, 1, 1040, -1050, 0);
        add_tick(SW_UP,     0, 0, 1000, -1000, 0);
        add_tick(SW_UP,     0, 0, 1000, -1000, 50);
        add_tick(SW_UP,     0, 0, 1000, -1000, -20);
        add_tick(SW_UP,     0, 0, 1000, -1000, 5000);
        add_tick(SW_UP,     0, 0, 1000, -1000, 5000);
        add_tick(SW_UP,     0, 0, 1000, -1000, 5000);
        // Other position keeps burst feed and still runs the jam counter.
        add_tick(SW_OTHER,  0, 0, 1000, -1000, 0);
        // Slow left wheel stops the feed; a fast negative one does not.
        add_tick(SW_UP,     0, 0, 400, -1000, 5000);
        add_tick(SW_UP,     0, 0, -600, -1000, 5000);
        add_tick(SW_UP,     0, 0, 1000, -1000, 0);
        add_tick(SW_UP,     0, 0, 1000, -1000, 0);
        // Target lost: count up to one below the threshold while the jam count is parked.
        for (int k = 0; k < 3; k++)
            add_tick(SW_MIDDLE, 0, 0, 1000, -1000, 5000);
        drain_all();

        // Lower both thresholds below the counts now held.
        write_cfg(CFG_LOST_TICKS, 16'd2);
        write_cfg(CFG_JAM_TICKS,  16'd1);
        add_tick(SW_MIDDLE, 0, 0, 1000, -1000, 5000);
        add_tick(SW_UP,     0, 0, 1000, -1000, 0);
        drain_all();

        // Zero jam threshold forces reverse at once; offline remote overrides the switch.
        write_cfg(CFG_JAM_TICKS, 16'd0);
        add_tick(SW_UP,    0, 0, 1000, -1000, 5000);
        add_tick(SW_UP,    1, 0, 1000, -1000, 5000);
        add_tick(SW_DOWN,  1, 1, 1000, -1000, 5000);
        add_tick(SW_OTHER, 1, 1, 1000, -1000, 5000);
        drain_all();

        // Random phases: sender light / receiver heavy idling, then swapped, then none.
        for (int r = 0; r < 10; r++) begin
            if (r < 4) begin
                send_idle_pct = 34;
                recv_idle_pct = 87;
            end else if (r < 8) begin
                send_idle_pct = 87;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            kind = (r == 3) ? SET_LOW : (r == 7) ? SET_HIGH : SET_RANDOM;
            for (int i = 0; i < 8; i++)
                write_cfg(t_cfg_index'(i), choose_setting(kind, t_cfg_index'(i)));
            // Hold the output off long enough to back requests up into the input.
            if (r == 1)
                stall_asked++;
            queue_random((kind == SET_RANDOM) ? 200 : 40);
            drain_all();
        end

        // Soak: hold the target-lost condition well past a large threshold at full rate.
        write_cfg(CFG_LOST_TICKS, CFG_W'(SOAK_LOST));
        for (int k = 0; k < SOAK_TICKS + 4; k++) begin
            t.sw      = SW_MIDDLE;
            t.offline = 1'($urandom_range(1));
            t.fire    = (k >= SOAK_TICKS) ? 1'($urandom_range(1)) : 1'b0;
            t.left    = SPEED_W'($urandom);
            t.right   = SPEED_W'($urandom);
            t.feeder  = SPEED_W'($urandom);
            pending_ticks.push_back(t);
        end
        drain_all();

        // Keep the clock running for TAIL_CYCLES so a stray extra result would still show up.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d ticks and %0d results over %0d register writes:",
                 ticks_taken, results_seen, cfg_writes);
        $display("directed cases, random runs under three idle patterns, a long output hold"
                 , " and a long target-lost soak.");
        if (error_count == 0 && status_due.size() == 0) begin
            $display("[launcher_feed_mode_controller] OK");
        end else begin
            $display("[launcher_feed_mode_controller] ERROR");
        end
        $finish;
    end

endmodule
